@@ hdl/ats_pkg.sv @@
// Shared types, constants and helpers for the assembler token scanner.
// No dependencies.
package ats_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_STRING = 2'd3
    } mode_t;

    localparam logic [4:0] KIND_IDENT      = 5'd0;
    localparam logic [4:0] KIND_NUMBER     = 5'd1;
    localparam logic [4:0] KIND_PUNCT_BASE = 5'd2;
    localparam logic [4:0] KIND_EOT        = 5'd18;

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    localparam int PUNCT_COUNT = 16;

    localparam logic [7:0] PUNCT_BYTES [PUNCT_COUNT] = '{
        8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h2B, 8'h3D, 8'h7B, 8'h7D, 8'h3B, 8'h2C
    };

    // Result queue depth; a byte yields at most two results.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] data;
        logic       carries;
        logic       first;
        logic       final_flag;
        logic       last;
    } result_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } punct_t;

    function automatic punct_t punct_lookup(input logic [7:0] b);
        punct_t p;
        p.hit = 1'b0;
        p.idx = '0;
        for (int k = 0; k < PUNCT_COUNT; k++) begin
            if (PUNCT_BYTES[k] == b) begin
                p.hit = 1'b1;
                p.idx = 4'(k);
            end
        end
        return p;
    endfunction

endpackage

@@ hdl/ats_classify.sv @@
// Byte classifier: decodes one source byte against the scanner state.
// Depends on ats_pkg.
module ats_classify
    import ats_pkg::*;
(
    input  mode_t      mode,
    input  logic       open_first,
    input  logic [7:0] text_byte,
    output result_t    res0,
    output result_t    res1,
    output logic [1:0] res_count,
    output mode_t      mode_next,
    output logic       open_first_next
);

    logic    is_letter;
    logic    is_digit;
    punct_t  punct;
    result_t marker;
    result_t eot;
    result_t fresh;
    logic    has_fresh;
    logic    has_close;

    assign is_letter = (text_byte >= 8'h41 && text_byte <= 8'h5A)
                    || (text_byte >= 8'h61 && text_byte <= 8'h7A);
    assign is_digit  = (text_byte >= 8'h30 && text_byte <= 8'h39);
    assign punct     = punct_lookup(text_byte);

    always_comb
    begin
        marker = '{kind: (mode == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT,
                   data: 8'h00, carries: 1'b0, first: open_first,
                   final_flag: 1'b1, last: 1'b0};
        eot    = '{kind: KIND_EOT, data: 8'h00, carries: 1'b0, first: 1'b1,
                   final_flag: 1'b1, last: 1'b0};
    end

    always_comb
    begin
        res0            = '0;
        res1            = '0;
        res_count       = 2'd0;
        mode_next       = mode;
        open_first_next = open_first;
        fresh           = '0;
        has_fresh       = 1'b0;
        has_close       = 1'b0;

        if (mode == MODE_STRING) begin
            if (text_byte == CH_QUOTE) begin
                res0            = marker;
                res_count       = 2'd1;
                mode_next       = MODE_IDLE;
                open_first_next = 1'b0;
            end else if (text_byte == CH_NUL) begin
                res0            = marker;
                res1            = eot;
                res_count       = 2'd2;
                mode_next       = MODE_IDLE;
                open_first_next = 1'b0;
            end else begin
                res0            = '{kind: KIND_IDENT, data: text_byte, carries: 1'b1,
                                    first: open_first, final_flag: 1'b0, last: 1'b0};
                res_count       = 2'd1;
                open_first_next = 1'b0;
            end
        end else if (mode == MODE_IDENT && (is_letter || text_byte == CH_UNDERSCORE)) begin
            res0      = '{kind: KIND_IDENT, data: text_byte, carries: 1'b1,
                          first: 1'b0, final_flag: 1'b0, last: 1'b0};
            res_count = 2'd1;
        end else if (mode == MODE_NUMBER && is_digit) begin
            res0      = '{kind: KIND_NUMBER, data: text_byte, carries: 1'b1,
                          first: 1'b0, final_flag: 1'b0, last: 1'b0};
            res_count = 2'd1;
        end else begin
            // Close any open token, then treat the byte as seen from idle
            has_close       = (mode != MODE_IDLE);
            mode_next       = MODE_IDLE;
            open_first_next = 1'b0;
            if (text_byte == CH_NUL) begin
                fresh     = eot;
                has_fresh = 1'b1;
            end else if (is_letter) begin
                fresh     = '{kind: KIND_IDENT, data: text_byte, carries: 1'b1,
                              first: 1'b1, final_flag: 1'b0, last: 1'b0};
                has_fresh = 1'b1;
                mode_next = MODE_IDENT;
            end else if (is_digit) begin
                fresh     = '{kind: KIND_NUMBER, data: text_byte, carries: 1'b1,
                              first: 1'b1, final_flag: 1'b0, last: 1'b0};
                has_fresh = 1'b1;
                mode_next = MODE_NUMBER;
            end else if (text_byte == CH_QUOTE) begin
                mode_next       = MODE_STRING;
                open_first_next = 1'b1;
            end else if (punct.hit) begin
                fresh     = '{kind: KIND_PUNCT_BASE + {1'b0, punct.idx}, data: text_byte,
                              carries: 1'b1, first: 1'b1, final_flag: 1'b1, last: 1'b0};
                has_fresh = 1'b1;
            end

            if (has_close) begin
                res0      = marker;
                res1      = fresh;
                res_count = has_fresh ? 2'd2 : 2'd1;
            end else begin
                res0      = fresh;
                res_count = has_fresh ? 2'd1 : 2'd0;
            end
        end

        // Flag the final result of this byte
        if (res_count == 2'd2) begin
            res1.last = 1'b1;
        end else begin
            res0.last = 1'b1;
        end
    end

endmodule

@@ hdl/ats_result_fifo.sv @@
// Result queue: takes up to two results a cycle, gives one a cycle.
// Depends on ats_pkg.
module ats_result_fifo
    import ats_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_count,
    input  result_t    push0,
    input  result_t    push1,
    input  logic       pop,
    output result_t    head,
    output logic       not_empty,
    output logic       room_for_two
);

    result_t            entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wptr_reg;
    logic [PTR_W-1:0]   wptr_next;
    logic [PTR_W-1:0]   rptr_reg;
    logic [PTR_W-1:0]   rptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_pop;
    logic [PTR_W-1:0]   wptr_plus1;

    assign not_empty    = (count_reg != '0);
    assign room_for_two = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign head         = entry_reg[rptr_reg];
    assign do_pop       = pop && not_empty;
    assign wptr_plus1   = wptr_reg + PTR_W'(1);

    always_comb
    begin
        wptr_next  = wptr_reg + PTR_W'(push_count);
        rptr_next  = do_pop ? rptr_reg + PTR_W'(1) : rptr_reg;
        count_next = count_reg + CNT_W'(push_count) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0) begin
            entry_reg[wptr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            entry_reg[wptr_plus1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue count overflow");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        PTR_W'(wptr_reg - rptr_reg) == PTR_W'(count_reg))
        else $error("result queue pointers disagree with count");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (push_count == 2'd2) |-> (count_reg <= CNT_W'(FIFO_DEPTH - 2)))
        else $error("result queue pushed without room");

endmodule

@@ hdl/assembler_token_scanner.sv @@
// Assembler token scanner: one source byte a beat in, token results out.
// Results of an accepted byte are registered in the result queue.
// Throughput: one byte a cycle while the queue has room for two results; a
// byte that closes a token and opens another gives two results, one per pop.
// Reset (rst_n low, asynchronous): scanner idle, no open token, queue empty.
// Depends on ats_pkg, ats_classify and ats_result_fifo.
module assembler_token_scanner
    import ats_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_ready,
    input  logic [7:0] text_byte,
    output logic       token_valid,
    input  logic       token_ready,
    output logic [4:0] token_kind,
    output logic [7:0] token_byte,
    output logic       carries_byte,
    output logic       token_first,
    output logic       token_final,
    output logic       run_last
);

    // Scanner state: what token is open and whether its first result is due
    mode_t      mode_reg;
    mode_t      mode_next;
    logic       open_first_reg;
    logic       open_first_next;

    result_t    res0;
    result_t    res1;
    logic [1:0] res_count;
    logic [1:0] push_count;
    logic       text_beat;
    result_t    head;

    // Take a byte only when the queue can hold both results it may cause
    assign text_beat  = text_valid && text_ready;
    assign push_count = text_beat ? res_count : 2'd0;

    ats_classify u_classify (
        .mode            (mode_reg),
        .open_first      (open_first_reg),
        .text_byte       (text_byte),
        .res0            (res0),
        .res1            (res1),
        .res_count       (res_count),
        .mode_next       (mode_next),
        .open_first_next (open_first_next)
    );

    // The queue entries are the result register; the head drives the port
    ats_result_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_count   (push_count),
        .push0        (res0),
        .push1        (res1),
        .pop          (token_ready),
        .head         (head),
        .not_empty    (token_valid),
        .room_for_two (text_ready)
    );

    assign token_kind   = head.kind;
    assign token_byte   = head.data;
    assign carries_byte = head.carries;
    assign token_first  = head.first;
    assign token_final  = head.final_flag;
    assign run_last     = head.last;

    // Advance the scanner state only on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= MODE_IDLE;
            open_first_reg <= 1'b0;
        end else if (text_beat) begin
            mode_reg       <= mode_next;
            open_first_reg <= open_first_next;
        end
    end

    a_hold_without_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !text_beat |=> ($stable(mode_reg) && $stable(open_first_reg)))
        else $error("scanner state moved without an input beat");

    a_first_only_in_string: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_STRING) |-> !open_first_reg)
        else $error("pending first flag outside a string");

    a_end_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (text_beat && text_byte == CH_NUL) |=> (mode_reg == MODE_IDLE))
        else $error("end of text did not return scanner to idle");

    a_continue_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (text_beat && mode_reg == MODE_NUMBER && text_byte >= 8'h30 && text_byte <= 8'h39)
        |-> (res_count == 2'd1 && res0.kind == KIND_NUMBER))
        else $error("digit inside a number did not give one number result");

endmodule
